// File: rtl/core/mcbq_pkg.sv
// Shared types, widths and codes for the multichannel cascaded biquad IIR unit.
package mcbq_pkg;

	localparam int WORD_W       = 32;
	localparam int ACC_W        = 64;
	localparam int FRAC_W       = 5;
	localparam int CHAN_W       = 3;
	localparam int SEC_FIELD_W  = 2;
	localparam int TAP_FIELD_W  = 2;
	localparam int FUNC_W       = 2;
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 40;

	localparam int CHANNELS_DEF = 8;
	localparam int SECTIONS_DEF = 4;
	localparam int TAPS_DEF     = 3;

	localparam logic [FRAC_W-1:0] FRAC_RST = 5'd14;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_FILTER = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		logic init;
		logic mul;
		logic sub;
	} mac_ctl_t;

endpackage

// File: rtl/core/mcbq_coef_mem.sv
// Coefficient store: one row of b and a taps per channel and section.
module mcbq_coef_mem import mcbq_pkg::*; #(
	parameter int ROWS  = CHANNELS_DEF * SECTIONS_DEF,
	parameter int LANES = 2 * TAPS_DEF,
	parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
	parameter int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [ROW_W-1:0]                  waddr,
	input  logic [LANE_W-1:0]                 wlane,
	input  logic [WORD_W-1:0]                 wdata,
	input  logic                              re,
	input  logic [ROW_W-1:0]                  raddr,
	output logic [LANES-1:0][WORD_W-1:0]      rdata
);

	logic [LANES-1:0][WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0][LANES-1:0]   vld_q;
	logic [LANES-1:0][WORD_W-1:0] rdata_q;
	logic [LANES-1:0]             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr][wlane] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= '0;
		end else begin
			if (we) begin
				vld_q[waddr][wlane] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rdata[l] = rvld_q[l] ? rdata_q[l] : '0;
		end
	end

endmodule

// File: rtl/core/mcbq_hist_mem.sv
// Delay line store: one row of x and y history per channel and section.
module mcbq_hist_mem import mcbq_pkg::*; #(
	parameter int ROWS  = CHANNELS_DEF * SECTIONS_DEF,
	parameter int LANES = 2 * TAPS_DEF,
	parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              we,
	input  logic [ROW_W-1:0]                  waddr,
	input  logic [LANES-1:0][WORD_W-1:0]      wdata,
	input  logic                              re,
	input  logic [ROW_W-1:0]                  raddr,
	output logic [LANES-1:0][WORD_W-1:0]      rdata
);

	logic [LANES-1:0][WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]              vld_q;
	logic [LANES-1:0][WORD_W-1:0] rdata_q;
	logic                         rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/core/mcbq_mac.sv
// Shared multiply-accumulate with rounding and fraction shift.
module mcbq_mac import mcbq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_ctl_t                 ctl,
	input  logic [WORD_W-1:0]        coef,
	input  logic [WORD_W-1:0]        data,
	input  logic [FRAC_W-1:0]        shift,
	output logic [WORD_W-1:0]        result
);

	logic signed [ACC_W-1:0] coef_ext;
	logic signed [ACC_W-1:0] data_ext;
	logic signed [ACC_W-1:0] prod_s1;
	logic                    vld_s1;
	logic                    sub_s1;
	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        half;

	assign coef_ext = ACC_W'($signed(coef));
	assign data_ext = ACC_W'($signed(data));
	assign half     = (shift == '0) ? '0 : (ACC_W'(1) << (shift - 1'b1));

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= coef_ext * data_ext;
			sub_s1  <= ctl.sub;
		end
		if (ctl.init) begin
			acc_q <= half;
		end else if (vld_s1) begin
			acc_q <= sub_s1 ? acc_q - ACC_W'(prod_s1) : acc_q + ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mul;
		end
	end

	assign result = WORD_W'(acc_q >> shift);

endmodule

// File: rtl/core/multichannel_cascaded_biquad_iir_unit.sv
// Top level: stream ports, item sequencer and output register of the biquad unit.
//
// Input stream s_axis_*: tuser carries the item kind (load coefficient, filter
// sample, clear delay lines), tdata the channel, section, tap, coefficient
// kind, coefficient value and sample. Output stream m_axis_* carries one
// filtered sample and its channel per filter item; loads and clears give none.
// cfg_we/cfg_wdata set the fraction bit count; write it only while idle.
// Load and clear items are done in the idle state. A filter item runs every section of its
// channel on one shared multiplier: per section one row read of coefficients
// and history, 2*TAPS-1 products, a drain step and a write-back step; the input
// is stalled until the sample's result is in the output register.
// A finished result sits in the output register, and the next item is taken
// while it waits; a second result waits in its last step until the register
// frees, with the input stalled meanwhile.
// Reset clears all coefficients and delay lines at once through valid bits and
// sets the fraction bit count to 14; no clearing pass is needed.
module multichannel_cascaded_biquad_iir_unit import mcbq_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int SECTIONS = SECTIONS_DEF,
	parameter int TAPS     = TAPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [FRAC_W-1:0]      cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// channel, section, tap, coef_kind, coef_value, sample
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// func
	input  logic [FUNC_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_channel, filtered, zero fill
	output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

	localparam int ROWS   = CHANNELS * SECTIONS;
	localparam int LANES  = 2 * TAPS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = $clog2(LANES);
	localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_RD    = 6'b000010,
		ST_MAC   = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_WB    = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [FRAC_W-1:0]         frac_q;
	logic [ROW_W-1:0]          row_q;
	logic [SEC_W-1:0]          sec_q;
	logic [LANE_W-1:0]         k_q;
	logic [WORD_W-1:0]         feed_q;
	logic [CHAN_W-1:0]         chan_q;
	logic                      out_vld_q;
	logic [OUT_DATA_W-1:0]     out_data_q;

	func_t                     in_func;
	logic [CHAN_W-1:0]         in_channel;
	logic [SEC_FIELD_W-1:0]    in_section;
	logic [TAP_FIELD_W-1:0]    in_tap;
	logic                      in_coef_kind;
	logic [WORD_W-1:0]         in_coef_value;
	logic [WORD_W-1:0]         in_sample;
	logic                      in_xfer;
	logic                      chan_ok;

	logic                      coef_we;
	logic [ROW_W-1:0]          coef_waddr;
	logic [LANE_W-1:0]         coef_wlane;
	logic                      rd_en;
	logic [ROW_W-1:0]          rd_addr;
	logic [ROW_W-1:0]          row_next;
	logic [LANES-1:0][WORD_W-1:0] coef_row;
	logic [LANES-1:0][WORD_W-1:0] hist_row;
	logic [LANES-1:0][WORD_W-1:0] hist_wrow;
	logic                      hist_clr;
	logic                      hist_we;
	logic                      last_sec;
	logic                      out_free;

	mac_ctl_t                  mac_ctl;
	logic [WORD_W-1:0]         mac_coef;
	logic [WORD_W-1:0]         mac_data;
	logic [WORD_W-1:0]         mac_result;

	assign in_func       = func_t'(s_axis_tuser);
	assign in_channel    = s_axis_tdata[2:0];
	assign in_section    = s_axis_tdata[4:3];
	assign in_tap        = s_axis_tdata[6:5];
	assign in_coef_kind  = s_axis_tdata[7];
	assign in_coef_value = s_axis_tdata[39:8];
	assign in_sample     = s_axis_tdata[71:40];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign chan_ok       = 32'(in_channel) < CHANNELS;

	assign coef_we    = in_xfer && (in_func == FUNC_LOAD) && chan_ok
	                    && (32'(in_section) < SECTIONS) && (32'(in_tap) < TAPS);
	assign coef_waddr = ROW_W'(32'(in_channel) * SECTIONS + 32'(in_section));
	assign coef_wlane = LANE_W'(32'(in_tap) + (in_coef_kind ? TAPS : 0));
	assign hist_clr   = in_xfer && (in_func == FUNC_CLEAR);

	assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
	assign row_next = row_q + 1'b1;
	assign rd_en    = (state_q == ST_RD) || ((state_q == ST_WB) && !last_sec);
	assign rd_addr  = (state_q == ST_WB) ? row_next : row_q;
	assign hist_we  = (state_q == ST_WB);
	assign out_free = !out_vld_q || m_axis_tready;

	always_comb begin
		mac_ctl.init = rd_en;
		mac_ctl.mul  = (state_q == ST_MAC);
		if (32'(k_q) < TAPS) begin
			mac_ctl.sub = 1'b0;
			mac_coef    = coef_row[k_q];
			mac_data    = (k_q == '0) ? feed_q : hist_row[LANE_W'(k_q - 1'b1)];
		end else begin
			mac_ctl.sub = 1'b1;
			mac_coef    = coef_row[LANE_W'(k_q + 1'b1)];
			mac_data    = hist_row[k_q];
		end
	end

	always_comb begin
		hist_wrow[0]    = feed_q;
		hist_wrow[TAPS] = mac_result;
		for (int t = 1; t < TAPS; t++) begin
			hist_wrow[t]        = hist_row[t-1];
			hist_wrow[TAPS + t] = hist_row[TAPS + t - 1];
		end
	end

	mcbq_coef_mem #(
		.ROWS  (ROWS),
		.LANES (LANES),
		.ROW_W (ROW_W),
		.LANE_W(LANE_W)
	) u_coef_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wlane (coef_wlane),
		.wdata (in_coef_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (coef_row)
	);

	mcbq_hist_mem #(
		.ROWS (ROWS),
		.LANES(LANES),
		.ROW_W(ROW_W)
	) u_hist_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (hist_clr),
		.we    (hist_we),
		.waddr (row_q),
		.wdata (hist_wrow),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (hist_row)
	);

	mcbq_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.coef  (mac_coef),
		.data  (mac_data),
		.shift (frac_q),
		.result(mac_result)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			chan_q <= in_channel;
		end
		if (in_xfer) begin
			feed_q <= in_sample;
		end else if (state_q == ST_WB) begin
			feed_q <= mac_result;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_data_q <= OUT_DATA_W'({mac_result, chan_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			frac_q    <= FRAC_RST;
			row_q     <= '0;
			sec_q     <= '0;
			k_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				frac_q <= cfg_wdata;
			end
			if ((state_q == ST_OUT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (in_func == FUNC_FILTER) && chan_ok) begin
						row_q   <= ROW_W'(32'(in_channel) * SECTIONS);
						sec_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					k_q     <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == LANE_W'(LANES - 2)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (last_sec) begin
						state_q <= ST_OUT;
					end else begin
						row_q   <= row_next;
						sec_q   <= sec_q + 1'b1;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: tb/sv/multichannel_cascaded_biquad_iir_unit_test.sv
// Self-checking stream testbench for the multichannel cascaded biquad IIR unit.
`timescale 1ns / 1ps

module multichannel_cascaded_biquad_iir_unit_test;
	import mcbq_pkg::*;

	localparam int PER_CH = SECTIONS_DEF * TAPS_DEF;
	localparam int DEPTH = CHANNELS_DEF * PER_CH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 75;
	localparam int PHASES = 6;
	localparam longint SAMPLE_SPAN = 65536;

	typedef struct {
		func_t                  func;
		logic [CHAN_W-1:0]      channel;
		logic [SEC_FIELD_W-1:0] section;
		logic [TAP_FIELD_W-1:0] tap;
		logic                   kind;
		logic [WORD_W-1:0]      coef;
		logic [WORD_W-1:0]      smp;
	} biquad_item_t;

	typedef struct {
		logic [CHAN_W-1:0] channel;
		logic [WORD_W-1:0] value;
	} filtered_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [FRAC_W-1:0]     cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [WORD_W-1:0] b_mem [DEPTH];
	logic [WORD_W-1:0] a_mem [DEPTH];
	logic [WORD_W-1:0] x_line [DEPTH];
	logic [WORD_W-1:0] y_line [DEPTH];
	int frac_model;

	biquad_item_t   item_backlog [$];
	biquad_item_t   in_flight;
	filtered_word_t awaited_outputs [$];
	filtered_word_t want;
	int pace_mode = 0;
	int fails = 0;
	int cycles = 0;

	multichannel_cascaded_biquad_iir_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void advance_filter(input biquad_item_t it);
		int base;
		int idx;
		int bw, xw, aw, yw;
		longint prod;
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] scaled;
		logic [WORD_W-1:0] v;
		case (it.func)
			FUNC_LOAD: begin
				if (it.channel < CHANNELS_DEF && it.section < SECTIONS_DEF && it.tap < TAPS_DEF) begin
					idx = it.tap + TAPS_DEF * it.section + PER_CH * it.channel;
					if (it.kind)
						a_mem[idx] = it.coef;
					else
						b_mem[idx] = it.coef;
				end
			end
			FUNC_FILTER: begin
				if (it.channel < CHANNELS_DEF) begin
					v = it.smp;
					for (int s = 0; s < SECTIONS_DEF; s++) begin
						base = PER_CH * it.channel + TAPS_DEF * s;
						for (int t = TAPS_DEF - 1; t > 0; t--) begin
							x_line[base + t] = x_line[base + t - 1];
							y_line[base + t] = y_line[base + t - 1];
						end
						x_line[base] = v;
						y_line[base] = '0;
						acc = '0;
						for (int t = 0; t < TAPS_DEF; t++) begin
							bw = b_mem[base + t];
							xw = x_line[base + t];
							aw = a_mem[base + t];
							yw = y_line[base + t];
							prod = longint'(bw) * longint'(xw);
							acc = acc + prod;
							prod = longint'(aw) * longint'(yw);
							acc = acc - prod;
						end
						if (frac_model != 0)
							acc = acc + (ACC_W'(1) << (frac_model - 1));
						scaled = acc >> frac_model;
						v = scaled[WORD_W-1:0];
						y_line[base] = v;
					end
					awaited_outputs.push_back('{it.channel, v});
				end
			end
			FUNC_CLEAR: begin
				for (int i = 0; i < DEPTH; i++) begin
					x_line[i] = '0;
					y_line[i] = '0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic biquad_item_t make_item(input func_t f, input int ch, input int sec,
			input int tp, input int kind, input logic [WORD_W-1:0] coef,
			input logic [WORD_W-1:0] smp);
		biquad_item_t it;
		it.func = f;
		it.channel = CHAN_W'(ch);
		it.section = SEC_FIELD_W'(sec);
		it.tap = TAP_FIELD_W'(tp);
		it.kind = kind[0];
		it.coef = coef;
		it.smp = smp;
		return it;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word(input longint lim);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom();
		if (pick == 4)
			return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		return WORD_W'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
	endfunction

	function automatic biquad_item_t random_item();
		biquad_item_t it;
		int pick;
		longint lim;
		pick = $urandom_range(0, 99);
		lim = longint'(1) << ((frac_model > 30) ? 30 : frac_model);
		it = make_item(FUNC_FILTER, $urandom_range(0, CHANNELS_DEF - 1),
			$urandom_range(0, SECTIONS_DEF - 1), $urandom_range(0, TAPS_DEF - 1),
			$urandom_range(0, 1), rand_word(lim), rand_word(SAMPLE_SPAN));
		if (pick < 3) begin
			it.func = FUNC_NONE;
		end else if (pick < 6) begin
			it.func = FUNC_CLEAR;
		end else if (pick < 32) begin
			it.func = FUNC_LOAD;
			if (pick < 9)
				it.tap = 2'd3;
		end
		return it;
	endfunction

	function automatic bit sender_gap();
		case (pace_mode)
			0: return $urandom_range(0, 99) < 18;
			1: return $urandom_range(0, 99) < 79;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_ready();
		case (pace_mode)
			0: return $urandom_range(0, 99) >= 79;
			1: return $urandom_range(0, 99) >= 18;
			default: return 1'b1;
		endcase
	endfunction

	task automatic settle_idle();
		while (item_backlog.size() != 0 || s_axis_tvalid || awaited_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fraction(input int fb);
		cfg_we <= 1'b1;
		cfg_wdata <= FRAC_W'(fb);
		@(posedge clk);
		cfg_we <= 1'b0;
		frac_model = fb;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				advance_filter(in_flight);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_backlog.size() != 0 && !sender_gap()) begin
					in_flight = item_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {in_flight.smp, in_flight.coef, in_flight.kind,
						in_flight.tap, in_flight.section, in_flight.channel};
					s_axis_tuser <= in_flight.func;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= receiver_ready();
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited_outputs.size() == 0) begin
				$error("unexpected transfer: out_channel %0d filtered %0d",
					m_axis_tdata[CHAN_W-1:0], $signed(m_axis_tdata[CHAN_W +: WORD_W]));
				fails++;
			end else begin
				want = awaited_outputs.pop_front();
				if (m_axis_tdata[CHAN_W-1:0] !== want.channel) begin
					$error("out_channel: expected %0d, actual %0d",
						want.channel, m_axis_tdata[CHAN_W-1:0]);
					fails++;
				end
				if (m_axis_tdata[CHAN_W +: WORD_W] !== want.value) begin
					$error("filtered: expected %0d, actual %0d",
						$signed(want.value), $signed(m_axis_tdata[CHAN_W +: WORD_W]));
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int plan [PHASES];
		int fb;
		plan = '{14, 30, 1, 0, 31, 14};
		for (int i = 0; i < DEPTH; i++) begin
			b_mem[i] = '0;
			a_mem[i] = '0;
			x_line[i] = '0;
			y_line[i] = '0;
		end
		frac_model = FRAC_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		item_backlog.push_back(make_item(FUNC_FILTER, 0, 0, 0, 0, '0, 32'd1000));
		for (int s = 0; s < SECTIONS_DEF; s++)
			item_backlog.push_back(make_item(FUNC_LOAD, 0, s, 0, 0, 32'h0000_4000, '0));
		item_backlog.push_back(make_item(FUNC_FILTER, 0, 0, 0, 0, '0, 32'd12345));
		item_backlog.push_back(make_item(FUNC_FILTER, 0, 0, 0, 0, '0, 32'h7fff_ffff));
		item_backlog.push_back(make_item(FUNC_FILTER, 0, 0, 0, 0, '0, 32'h8000_0000));
		for (int s = 0; s < SECTIONS_DEF; s++)
			item_backlog.push_back(make_item(FUNC_LOAD, 7, s, 0, 0, 32'h7fff_ffff, '0));
		item_backlog.push_back(make_item(FUNC_LOAD, 7, 3, 2, 1, 32'h8000_0000, '0));
		item_backlog.push_back(make_item(FUNC_LOAD, 7, 3, 1, 0, 32'h7fff_ffff, '0));
		item_backlog.push_back(make_item(FUNC_LOAD, 0, 0, 3, 0, 32'hdead_beef, '0));
		item_backlog.push_back(make_item(FUNC_NONE, 5, 2, 1, 1, $urandom(), $urandom()));
		item_backlog.push_back(make_item(FUNC_FILTER, 7, 0, 0, 0, '0, 32'h7fff_ffff));
		item_backlog.push_back(make_item(FUNC_FILTER, 7, 0, 0, 0, '0, 32'h8000_0000));
		item_backlog.push_back(make_item(FUNC_FILTER, 7, 0, 0, 0, '0, 32'hffff_ffff));
		item_backlog.push_back(make_item(FUNC_CLEAR, 0, 0, 0, 0, '0, '0));
		item_backlog.push_back(make_item(FUNC_FILTER, 7, 0, 0, 0, '0, '0));
		item_backlog.push_back(make_item(FUNC_FILTER, 0, 0, 0, 0, '0, 32'hffff_ffff));

		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle_idle();
				if (p == 2)
					pace_mode = 1;
				if (p == 4)
					pace_mode = 2;
				fb = (p == PHASES - 1) ? $urandom_range(2, 29) : plan[p];
				write_fraction(fb);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == PHASE_ITEMS / 2)
					settle_idle();
				item_backlog.push_back(random_item());
			end
		end

		settle_idle();
		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/mcbq_pkg.sv
rtl/core/mcbq_coef_mem.sv
rtl/core/mcbq_hist_mem.sv
rtl/core/mcbq_mac.sv
rtl/core/multichannel_cascaded_biquad_iir_unit.sv
tb/sv/multichannel_cascaded_biquad_iir_unit_test.sv
